>>> hdl/rwp_pkg.sv
// shared types and codes for the riff/wave pcm stream parser
// no dependencies; imported by riff_wav_pcm_stream_parser
package rwp_pkg;

  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;

  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_HEADER = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_NOT_WAVE    = 3'd1;
  localparam logic [2:0] ST_NOT_PCM     = 3'd2;
  localparam logic [2:0] ST_BAD_BITS    = 3'd3;
  localparam logic [2:0] ST_BAD_CHANS   = 3'd4;
  localparam logic [2:0] ST_NO_DATA     = 3'd5;
  localparam logic [2:0] ST_SHORT_FMT   = 3'd6;
  localparam logic [2:0] ST_DATA_EARLY  = 3'd7;

  localparam int unsigned QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [15:0] sample_value;
    logic               channel_index;
    logic [31:0]        rate_hz;
    logic [1:0]         channel_count;
    logic [31:0]        frames_total;
    logic [2:0]         status_code;
    logic               last_result;
  } result_t;

endpackage

>>> hdl/riff_wav_pcm_stream_parser.sv
// an accepted byte is held in the input stage, then parsed into the result queue that drives the output
// throughput: one byte per cycle; a byte may cause up to two results, drained one per
//   cycle while out_ready is high from a four-entry result queue, so a byte waits only
//   while the queue holds more than two results
// reset: synchronous, active low; clears file_length, the parse state and the queue
// depends on rwp_pkg
module riff_wav_pcm_stream_parser (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [31:0]          cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_file_byte,
  input  logic                 in_first_byte,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_kind,
  output logic signed [15:0]   out_sample_value,
  output logic                 out_channel_index,
  output logic [31:0]          out_rate_hz,
  output logic [1:0]           out_channel_count,
  output logic [31:0]          out_frames_total,
  output logic [2:0]           out_status_code,
  output logic                 out_last_result
);
  import rwp_pkg::*;

  typedef enum logic [2:0] {
    PH_RIFF, PH_TAG, PH_LEN, PH_FMT, PH_SKIP, PH_DATA, PH_DONE
  } phase_t;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

  // input stage
  logic       in_vld_r;
  logic [7:0] byte_r;
  logic       first_r;
  logic       proc;

  // parse state
  phase_t      phase_r, phase_nxt;
  logic [31:0] flen_r;
  logic [31:0] pos_r, pos_nxt;
  logic [31:0] tag_r, tag_nxt;
  logic [31:0] len_r, len_nxt;
  logic [32:0] left_r, left_nxt;
  logic [15:0] fcode_r, fcode_nxt;
  logic [15:0] fch_r, fch_nxt;
  logic [31:0] frate_r, frate_nxt;
  logic [15:0] fbits_r, fbits_nxt;
  logic        fseen_r, fseen_nxt;
  logic [31:0] sleft_r, sleft_nxt;
  logic [7:0]  lowb_r, lowb_nxt;
  logic        tog_r, tog_nxt;
  logic [2:0]  err_r, err_nxt;

  // results of one byte
  result_t     res_a, res_s, push0, push1;
  logic        a_vld, s_vld;
  logic [2:0]  chk;
  logic [32:0] fmt_off;
  logic [33:0] end_sum;
  logic [31:0] frames;

  // result queue
  result_t           q_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_r, rd_r;
  logic [PTR_W:0]    cnt_r;
  logic              pop;
  logic [1:0]        n_push;

  function automatic logic [2:0] fmt_check(input logic [15:0] code, input logic [15:0] bits,
                                           input logic [15:0] chans);
    logic [2:0] c;
    if (code != 16'd1) c = ST_NOT_PCM;
    else if (bits != 16'd8 && bits != 16'd16) c = ST_BAD_BITS;
    else if (chans < 16'd1 || chans > 16'd2) c = ST_BAD_CHANS;
    else c = ST_OK;
    return c;
  endfunction

  assign proc     = in_vld_r && (cnt_r <= (PTR_W+1)'(QUEUE_DEPTH - 2));
  assign in_ready = !in_vld_r || proc;
  assign pop      = out_valid && out_ready;

  always_comb begin
    if (first_r) begin
      phase_nxt = PH_RIFF; pos_nxt = '0; tag_nxt = '0; len_nxt = '0; left_nxt = '0;
      fcode_nxt = '0; fch_nxt = '0; frate_nxt = '0; fbits_nxt = '0; fseen_nxt = 1'b0;
      sleft_nxt = '0; lowb_nxt = '0; tog_nxt = 1'b0; err_nxt = '0;
    end else begin
      phase_nxt = phase_r; pos_nxt = pos_r; tag_nxt = tag_r; len_nxt = len_r;
      left_nxt = left_r; fcode_nxt = fcode_r; fch_nxt = fch_r; frate_nxt = frate_r;
      fbits_nxt = fbits_r; fseen_nxt = fseen_r; sleft_nxt = sleft_r; lowb_nxt = lowb_r;
      tog_nxt = tog_r; err_nxt = err_r;
    end
    a_vld   = 1'b0;
    s_vld   = 1'b0;
    res_a   = '0;
    res_s   = '0;
    res_s.kind = KIND_STATUS;
    chk     = ST_OK;
    fmt_off = '0;
    end_sum = '0;
    frames  = '0;

    if (phase_nxt != PH_DONE) begin
      unique case (phase_nxt)
        PH_RIFF: begin
          tag_nxt = {tag_nxt[23:0], byte_r};
          if (pos_nxt == 32'd3 && tag_nxt != TAG_RIFF) begin
            s_vld = 1'b1; res_s.status_code = ST_NOT_WAVE;
          end else if (pos_nxt == 32'd11) begin
            if (tag_nxt != TAG_WAVE) begin
              s_vld = 1'b1; res_s.status_code = ST_NOT_WAVE;
            end else begin
              phase_nxt = PH_TAG; left_nxt = 33'd4; tag_nxt = '0;
            end
          end
        end
        PH_TAG: begin
          tag_nxt  = {tag_nxt[23:0], byte_r};
          left_nxt = left_nxt - 33'd1;
          if (left_nxt == '0) begin
            phase_nxt = PH_LEN; left_nxt = 33'd4; len_nxt = '0;
          end
        end
        PH_LEN: begin
          len_nxt  = {byte_r, len_nxt[31:8]};
          left_nxt = left_nxt - 33'd1;
          if (left_nxt == '0) begin
            // chunk header complete
            end_sum = {2'b00, pos_nxt} + 34'd1 + {2'b00, len_nxt};
            chk     = fmt_check(fcode_nxt, fbits_nxt, fch_nxt);
            if (end_sum > {2'b00, flen_r}) begin
              s_vld = 1'b1;
              res_s.status_code = (chk == ST_OK) ? ST_NO_DATA : chk;
            end else if (tag_nxt == TAG_FMT) begin
              if (len_nxt < 32'd16) begin
                s_vld = 1'b1; res_s.status_code = ST_SHORT_FMT;
              end else begin
                fseen_nxt = 1'b1;
                phase_nxt = PH_FMT;
                left_nxt  = {1'b0, len_nxt} + {32'd0, len_nxt[0]};
              end
            end else if (tag_nxt == TAG_DATA) begin
              if (!fseen_nxt) begin
                s_vld = 1'b1; res_s.status_code = ST_DATA_EARLY;
              end else if (chk != ST_OK) begin
                s_vld = 1'b1; res_s.status_code = chk;
              end else if (len_nxt == '0) begin
                s_vld = 1'b1; res_s.status_code = ST_NO_DATA;
              end else begin
                // bytes per frame is 1, 2 or 4
                if (fbits_nxt == 16'd8) frames = (fch_nxt == 16'd2) ? len_nxt >> 1 : len_nxt;
                else frames = (fch_nxt == 16'd2) ? len_nxt >> 2 : len_nxt >> 1;
                sleft_nxt = (fch_nxt == 16'd2) ? {frames[30:0], 1'b0} : frames;
                tog_nxt   = 1'b0;
                left_nxt  = {1'b0, len_nxt};
                phase_nxt = PH_DATA;
                a_vld = 1'b1;
                res_a.kind          = KIND_HEADER;
                res_a.rate_hz       = frate_nxt;
                res_a.channel_count = fch_nxt[1:0];
                res_a.frames_total  = frames;
              end
            end else begin
              left_nxt = {1'b0, len_nxt} + {32'd0, len_nxt[0]};
              if (left_nxt == '0) begin
                phase_nxt = PH_TAG; left_nxt = 33'd4; tag_nxt = '0;
              end else begin
                phase_nxt = PH_SKIP;
              end
            end
          end
        end
        PH_FMT: begin
          fmt_off = ({1'b0, len_nxt} + {32'd0, len_nxt[0]}) - left_nxt;
          if (fmt_off < 33'd2) begin
            if (!fmt_off[0]) fcode_nxt[7:0] = byte_r; else fcode_nxt[15:8] = byte_r;
          end else if (fmt_off < 33'd4) begin
            if (!fmt_off[0]) fch_nxt[7:0] = byte_r; else fch_nxt[15:8] = byte_r;
          end else if (fmt_off < 33'd8) begin
            unique case (fmt_off[1:0])
              2'd0: frate_nxt[7:0]   = byte_r;
              2'd1: frate_nxt[15:8]  = byte_r;
              2'd2: frate_nxt[23:16] = byte_r;
              default: frate_nxt[31:24] = byte_r;
            endcase
          end else if (fmt_off == 33'd14) begin
            fbits_nxt[7:0] = byte_r;
          end else if (fmt_off == 33'd15) begin
            fbits_nxt[15:8] = byte_r;
          end
          left_nxt = left_nxt - 33'd1;
          if (left_nxt == '0) begin
            phase_nxt = PH_TAG; left_nxt = 33'd4; tag_nxt = '0;
          end
        end
        PH_SKIP: begin
          left_nxt = left_nxt - 33'd1;
          if (left_nxt == '0) begin
            phase_nxt = PH_TAG; left_nxt = 33'd4; tag_nxt = '0;
          end
        end
        PH_DATA: begin
          if (sleft_nxt != '0) begin
            if (fbits_nxt == 16'd8) begin
              a_vld = 1'b1;
              res_a.sample_value = {byte_r ^ 8'h80, 8'h00};
            end else if (!(len_nxt[0] ^ left_nxt[0])) begin
              // low byte of a 16-bit sample
              lowb_nxt = byte_r;
            end else begin
              a_vld = 1'b1;
              res_a.sample_value = {byte_r, lowb_nxt};
            end
            if (a_vld) begin
              res_a.kind          = KIND_SAMPLE;
              res_a.channel_index = tog_nxt;
              tog_nxt   = (fch_nxt == 16'd2) ? !tog_nxt : 1'b0;
              sleft_nxt = sleft_nxt - 32'd1;
            end
          end
          left_nxt = left_nxt - 33'd1;
          if (left_nxt == '0) begin
            s_vld = 1'b1; res_s.status_code = ST_OK;
          end
        end
        default: ;
      endcase

      if (s_vld) begin
        phase_nxt = PH_DONE;
      end else if ({1'b0, pos_nxt} + 33'd1 >= {1'b0, flen_r}) begin
        // end of file reached without a data chunk
        s_vld = 1'b1;
        if (phase_nxt == PH_RIFF) res_s.status_code = ST_NOT_WAVE;
        else begin
          chk = fmt_check(fcode_nxt, fbits_nxt, fch_nxt);
          res_s.status_code = (chk == ST_OK) ? ST_NO_DATA : chk;
        end
        phase_nxt = PH_DONE;
      end
      if (s_vld) err_nxt = res_s.status_code;
    end
    pos_nxt = pos_nxt + 32'd1;

    res_s.last_result = 1'b1;
    res_a.last_result = !s_vld;
    push0  = a_vld ? res_a : res_s;
    push1  = res_s;
    n_push = {1'b0, a_vld} + {1'b0, s_vld};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      first_r  <= 1'b0;
      flen_r   <= '0;
      phase_r  <= PH_RIFF;
      pos_r    <= '0;
      tag_r    <= '0;
      len_r    <= '0;
      left_r   <= '0;
      fcode_r  <= '0;
      fch_r    <= '0;
      frate_r  <= '0;
      fbits_r  <= '0;
      fseen_r  <= 1'b0;
      sleft_r  <= '0;
      lowb_r   <= '0;
      tog_r    <= 1'b0;
      err_r    <= '0;
      wr_r     <= '0;
      rd_r     <= '0;
      cnt_r    <= '0;
    end else begin
      if (cfg_we) begin
        flen_r <= cfg_wdata;
      end
      if (in_ready) begin
        in_vld_r <= in_valid;
        first_r  <= in_first_byte;
      end
      if (proc) begin
        phase_r <= phase_nxt;
        pos_r   <= pos_nxt;
        tag_r   <= tag_nxt;
        len_r   <= len_nxt;
        left_r  <= left_nxt;
        fcode_r <= fcode_nxt;
        fch_r   <= fch_nxt;
        frate_r <= frate_nxt;
        fbits_r <= fbits_nxt;
        fseen_r <= fseen_nxt;
        sleft_r <= sleft_nxt;
        lowb_r  <= lowb_nxt;
        tog_r   <= tog_nxt;
        err_r   <= err_nxt;
        wr_r    <= wr_r + PTR_W'(n_push);
      end
      if (pop) begin
        rd_r <= rd_r + PTR_W'(1);
      end
      cnt_r <= cnt_r + (proc ? (PTR_W+1)'(n_push) : '0) - (PTR_W+1)'(pop);
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      byte_r <= in_file_byte;
    end
    if (proc && n_push != 2'd0) begin
      q_r[wr_r] <= push0;
    end
    if (proc && n_push == 2'd2) begin
      q_r[wr_r + PTR_W'(1)] <= push1;
    end
  end

  assign out_valid         = (cnt_r != '0);
  assign out_kind          = q_r[rd_r].kind;
  assign out_sample_value  = q_r[rd_r].sample_value;
  assign out_channel_index = q_r[rd_r].channel_index;
  assign out_rate_hz       = q_r[rd_r].rate_hz;
  assign out_channel_count = q_r[rd_r].channel_count;
  assign out_frames_total  = q_r[rd_r].frames_total;
  assign out_status_code   = q_r[rd_r].status_code;
  assign out_last_result   = q_r[rd_r].last_result;

`ifndef NO_ASSERTIONS
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (PTR_W+1)'(QUEUE_DEPTH))
    else $error("result queue overflow");

  a_status_ends_parse: assert property (@(posedge clk) disable iff (!rst_n)
    proc && s_vld |=> phase_r == PH_DONE && err_r == $past(res_s.status_code))
    else $error("status given but parse not closed");

  a_done_is_silent: assert property (@(posedge clk) disable iff (!rst_n)
    proc && phase_r == PH_DONE && !first_r |-> n_push == 2'd0)
    else $error("result after final status");

  a_sample_needs_data: assert property (@(posedge clk) disable iff (!rst_n)
    proc && a_vld && res_a.kind == KIND_SAMPLE |-> phase_r == PH_DATA && !first_r)
    else $error("sample outside data chunk");
`endif

endmodule

>>> tb/tb_riff_wav_pcm_stream_parser.sv
// self-checking testbench for riff_wav_pcm_stream_parser: short directed table, then
// randomly built wav files checked against a byte-level parse predictor
// depends on rwp_pkg and the parser rtl
`timescale 1ns / 100ps

module tb_riff_wav_pcm_stream_parser;
  import rwp_pkg::*;

  typedef enum logic [2:0] {
    WALK_RIFF, WALK_TAG, WALK_LEN, WALK_FMT, WALK_SKIP, WALK_DATA, WALK_DONE
  } walk_t;

  typedef enum logic [1:0] {CHK_MODEL, CHK_STATUS, CHK_NONE} chk_t;

  typedef struct {
    bit          set_len;
    logic [31:0] len;
    logic [7:0]  b;
    logic        f;
    chk_t        chk;
    logic [2:0]  st;
  } dir_row_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               cfg_we;
  logic [31:0]        cfg_wdata;
  logic               in_valid;
  logic               in_ready;
  logic [7:0]         in_file_byte;
  logic               in_first_byte;
  logic               out_valid;
  logic               out_ready;
  logic [1:0]         out_kind;
  logic signed [15:0] out_sample_value;
  logic               out_channel_index;
  logic [31:0]        out_rate_hz;
  logic [1:0]         out_channel_count;
  logic [31:0]        out_frames_total;
  logic [2:0]         out_status_code;
  logic               out_last_result;

  // parse predictor state
  logic [31:0] len_reg;
  logic [31:0] pos;
  walk_t       walk;
  logic [31:0] tag;
  logic [31:0] clen;
  logic [32:0] left;
  logic [15:0] f_code;
  logic [15:0] f_ch;
  logic [31:0] f_rate;
  logic [15:0] f_bits;
  bit          f_seen;
  logic [31:0] smp_left;
  logic [7:0]  hold;
  logic        tog;
  logic [2:0]  err_code;

  result_t     step_q[$];
  result_t     parse_q[$];
  logic [7:0]  file_q[$];
  dir_row_t    dir_tab[$];
  int          bad_count = 0;
  int          tx_idle_pct = 0;
  int          rx_stall_pct = 0;

  riff_wav_pcm_stream_parser dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_file_byte      (in_file_byte),
    .in_first_byte     (in_first_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_kind          (out_kind),
    .out_sample_value  (out_sample_value),
    .out_channel_index (out_channel_index),
    .out_rate_hz       (out_rate_hz),
    .out_channel_count (out_channel_count),
    .out_frames_total  (out_frames_total),
    .out_status_code   (out_status_code),
    .out_last_result   (out_last_result)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #5ms;
    $display("RESULT: ERROR");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void clear_walk();
    pos = '0; walk = WALK_RIFF; tag = '0; clen = '0; left = '0;
    f_code = '0; f_ch = '0; f_rate = '0; f_bits = '0; f_seen = 0;
    smp_left = '0; hold = '0; tog = 1'b0; err_code = ST_OK;
  endfunction

  function automatic void emit(logic [1:0] k, logic [15:0] s, logic ch, logic [31:0] r,
                               logic [1:0] c, logic [31:0] fr, logic [2:0] st);
    result_t x;
    x.kind = k; x.sample_value = s; x.channel_index = ch; x.rate_hz = r;
    x.channel_count = c; x.frames_total = fr; x.status_code = st; x.last_result = 1'b0;
    step_q.push_back(x);
  endfunction

  function automatic void close_file(logic [2:0] code);
    err_code = code;
    walk = WALK_DONE;
    emit(KIND_STATUS, '0, 1'b0, '0, '0, '0, code);
  endfunction

  function automatic logic [2:0] fmt_verdict();
    if (f_code != 16'd1) return ST_NOT_PCM;
    if (f_bits != 16'd8 && f_bits != 16'd16) return ST_BAD_BITS;
    if (f_ch < 16'd1 || f_ch > 16'd2) return ST_BAD_CHANS;
    return ST_OK;
  endfunction

  function automatic void end_of_walk();
    logic [2:0] c;
    if (walk == WALK_RIFF) begin
      c = ST_NOT_WAVE;
    end else begin
      c = fmt_verdict();
      if (c == ST_OK) c = ST_NO_DATA;
    end
    close_file(c);
  endfunction

  function automatic void to_tag();
    walk = WALK_TAG; left = 33'd4; tag = '0;
  endfunction

  function automatic void put_sample(logic [15:0] v);
    emit(KIND_SAMPLE, v, tog, '0, '0, '0, ST_OK);
    tog = (f_ch == 16'd2) ? ~tog : 1'b0;
    smp_left = smp_left - 32'd1;
  endfunction

  function automatic logic [15:0] set_half(logic [15:0] f, logic hi, logic [7:0] b);
    return hi ? {b, f[7:0]} : {f[15:8], b};
  endfunction

  function automatic void chunk_header_done();
    logic [33:0] reach;
    logic [2:0]  c;
    logic [31:0] bpf;
    logic [31:0] frames;
    reach = 34'(pos) + 34'd1 + 34'(clen);
    if (reach > 34'(len_reg)) begin
      end_of_walk();
      return;
    end
    if (tag == TAG_FMT) begin
      if (clen < 32'd16) begin
        close_file(ST_SHORT_FMT);
        return;
      end
      f_seen = 1;
      walk = WALK_FMT;
      left = 33'(clen) + 33'(clen[0]);
    end else if (tag == TAG_DATA) begin
      if (!f_seen) begin
        close_file(ST_DATA_EARLY);
        return;
      end
      c = fmt_verdict();
      if (c != ST_OK) begin
        close_file(c);
        return;
      end
      if (clen == 32'd0) begin
        close_file(ST_NO_DATA);
        return;
      end
      bpf = 32'(f_ch) * 32'(f_bits / 16'd8);
      frames = clen / bpf;
      smp_left = frames * 32'(f_ch);
      tog = 1'b0;
      left = 33'(clen);
      walk = WALK_DATA;
      emit(KIND_HEADER, '0, 1'b0, f_rate, f_ch[1:0], frames, ST_OK);
    end else begin
      left = 33'(clen) + 33'(clen[0]);
      if (left == '0) to_tag();
      else walk = WALK_SKIP;
    end
  endfunction

  function automatic void parse_one(logic [7:0] b);
    logic [32:0] off;
    case (walk)
      WALK_RIFF: begin
        tag = {tag[23:0], b};
        if (pos == 32'd3 && tag != TAG_RIFF) begin
          close_file(ST_NOT_WAVE);
        end else if (pos == 32'd11) begin
          if (tag != TAG_WAVE) close_file(ST_NOT_WAVE);
          else to_tag();
        end
      end
      WALK_TAG: begin
        tag = {tag[23:0], b};
        left = left - 33'd1;
        if (left == '0) begin
          walk = WALK_LEN; left = 33'd4; clen = '0;
        end
      end
      WALK_LEN: begin
        clen = {b, clen[31:8]};
        left = left - 33'd1;
        if (left == '0) chunk_header_done();
      end
      WALK_FMT: begin
        off = 33'(clen) + 33'(clen[0]) - left;
        if (off < 33'd2) f_code = set_half(f_code, off[0], b);
        else if (off < 33'd4) f_ch = set_half(f_ch, off[0], b);
        else if (off < 33'd8) f_rate[off[1:0]*8 +: 8] = b;
        else if (off == 33'd14 || off == 33'd15) f_bits = set_half(f_bits, off[0], b);
        left = left - 33'd1;
        if (left == '0) to_tag();
      end
      WALK_SKIP: begin
        left = left - 33'd1;
        if (left == '0) to_tag();
      end
      WALK_DATA: begin
        off = 33'(clen) - left;
        if (smp_left != '0) begin
          if (f_bits == 16'd8) put_sample({b ^ 8'h80, 8'h00});
          else if (!off[0]) hold = b;
          else put_sample({b, hold});
        end
        left = left - 33'd1;
        if (left == '0) close_file(ST_OK);
      end
      default: ;
    endcase
  endfunction

  function automatic void parse_step(logic [7:0] b, logic f);
    step_q.delete();
    if (f) clear_walk();
    if (walk != WALK_DONE) begin
      parse_one(b);
      if (walk != WALK_DONE && (33'(pos) + 33'd1 >= 33'(len_reg))) end_of_walk();
    end
    pos = pos + 32'd1;
    if (step_q.size() > 0) step_q[step_q.size()-1].last_result = 1'b1;
  endfunction

  // ---------------------------------------------------------------- drivers

  task automatic load_file_length(input logic [31:0] v);
    in_valid <= 1'b0;
    while (parse_q.size() != 0) @(negedge clk);
    // bytes after a status give no result, so let the pipe drain
    repeat (8) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    len_reg = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_byte(input logic [7:0] b, input logic f, input chk_t chk,
                           input logic [2:0] st);
    result_t typed;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_file_byte <= b;
    in_first_byte <= f;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    parse_step(b, f);
    case (chk)
      CHK_MODEL: foreach (step_q[i]) parse_q.push_back(step_q[i]);
      CHK_STATUS: begin
        typed = '0;
        typed.kind = KIND_STATUS;
        typed.status_code = st;
        typed.last_result = 1'b1;
        parse_q.push_back(typed);
      end
      default: ;
    endcase
    @(negedge clk);
  endtask

  always @(negedge clk) out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);

  function automatic string show(result_t r);
    return $sformatf("kind=%0d smp=%0d ch=%0d rate=%0h cnt=%0d frames=%0d st=%0d last=%0d",
                     r.kind, r.sample_value, r.channel_index, r.rate_hz, r.channel_count,
                     r.frames_total, r.status_code, r.last_result);
  endfunction

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      got.kind = out_kind;
      got.sample_value = out_sample_value;
      got.channel_index = out_channel_index;
      got.rate_hz = out_rate_hz;
      got.channel_count = out_channel_count;
      got.frames_total = out_frames_total;
      got.status_code = out_status_code;
      got.last_result = out_last_result;
      if (parse_q.size() == 0) begin
        if (bad_count < 10) $display("unexpected result: %s", show(got));
        bad_count++;
      end else begin
        want = parse_q.pop_front();
        if (got.kind !== want.kind || got.sample_value !== want.sample_value ||
            got.channel_index !== want.channel_index || got.rate_hz !== want.rate_hz ||
            got.channel_count !== want.channel_count ||
            got.frames_total !== want.frames_total ||
            got.status_code !== want.status_code ||
            got.last_result !== want.last_result) begin
          if (bad_count < 10) begin
            $display("mismatch at %0t", $realtime);
            $display("  expected %s", show(want));
            $display("  actual   %s", show(got));
          end
          bad_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- file builder

  function automatic void put8(logic [7:0] b);
    file_q.push_back(b);
  endfunction

  function automatic void put_tag(logic [31:0] t);
    put8(t[31:24]); put8(t[23:16]); put8(t[15:8]); put8(t[7:0]);
  endfunction

  function automatic void put_le32(logic [31:0] v);
    put8(v[7:0]); put8(v[15:8]); put8(v[23:16]); put8(v[31:24]);
  endfunction

  function automatic void put_other_chunk();
    int unsigned n;
    n = $urandom_range(0, 5);
    put_tag(32'($urandom));
    put_le32(32'(n));
    repeat (n) put8(8'($urandom));
    if (n % 2) put8(8'($urandom));
  endfunction

  function automatic void put_fmt_chunk(bit short_len);
    logic [7:0]  fbody [20];
    int unsigned n;
    logic [15:0] fc;
    logic [15:0] ch;
    logic [15:0] bw;
    if (short_len) n = $urandom_range(0, 15);
    else n = ($urandom_range(0, 3) == 0) ? $urandom_range(17, 20) : 16;
    fc = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'd1;
    case ($urandom_range(0, 11))
      0: ch = 16'd0;
      1: ch = 16'd3;
      2: ch = 16'($urandom);
      default: ch = 16'($urandom_range(1, 2));
    endcase
    case ($urandom_range(0, 11))
      0: bw = 16'($urandom);
      1: bw = 16'd24;
      default: bw = $urandom_range(0, 1) ? 16'd16 : 16'd8;
    endcase
    foreach (fbody[i]) fbody[i] = 8'($urandom);
    fbody[0] = fc[7:0];  fbody[1] = fc[15:8];
    fbody[2] = ch[7:0];  fbody[3] = ch[15:8];
    fbody[14] = bw[7:0]; fbody[15] = bw[15:8];
    put_tag(TAG_FMT);
    put_le32(32'(n));
    for (int i = 0; i < n; i++) put8(fbody[i]);
    if (n % 2) put8(8'($urandom));
  endfunction

  function automatic void put_data_chunk();
    int unsigned n;
    logic [31:0] lf;
    logic        hi;
    logic        lo;
    n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 20);
    // now and then a length far past the bytes sent, to hit the overrun check
    lf = ($urandom_range(0, 11) == 0) ? 32'($urandom) : 32'(n);
    put_tag(TAG_DATA);
    put_le32(lf);
    for (int i = 0; i < n; i++) begin
      hi = 1'($urandom);
      lo = 1'($urandom);
      // full-scale codes show up often
      if ($urandom_range(0, 3) == 0) put8({hi, {7{lo}}});
      else put8(8'($urandom));
    end
    if (n % 2) put8(8'($urandom));
  endfunction

  task automatic build_file(output logic [31:0] flen, output bit noisy);
    int unsigned v;
    int unsigned nb;
    file_q.delete();
    noisy = 0;
    v = $urandom_range(0, 19);
    if (v == 0) begin
      noisy = 1;
      if ($urandom_range(0, 1)) put_tag(TAG_RIFF);
      nb = $urandom_range(1, 16);
      repeat (nb) put8(8'($urandom));
    end else begin
      put_tag((v == 1) ? 32'($urandom) : TAG_RIFF);
      put_le32(32'($urandom));
      put_tag((v == 2) ? (TAG_WAVE ^ (32'h1 << $urandom_range(0, 31))) : TAG_WAVE);
      if ($urandom_range(0, 3) == 0) put_other_chunk();
      if (v == 3) put_data_chunk();
      repeat (($urandom_range(0, 7) == 0) ? 2 : 1) put_fmt_chunk(v == 4);
      if ($urandom_range(0, 5) == 0) put_other_chunk();
      if (v != 5) put_data_chunk();
      if ($urandom_range(0, 3) == 0) put_data_chunk();
    end
    case ($urandom_range(0, 9))
      0: flen = '1;
      1: flen = 32'($urandom_range(0, file_q.size()));
      2: flen = 32'($urandom_range(0, 13));
      default: flen = 32'(file_q.size());
    endcase
  endtask

  function automatic void add_row(bit set_len, logic [31:0] len, logic [7:0] b, logic f,
                                  chk_t chk, logic [2:0] st);
    dir_row_t r;
    r.set_len = set_len; r.len = len; r.b = b; r.f = f; r.chk = chk; r.st = st;
    dir_tab.push_back(r);
  endfunction

  // ---------------------------------------------------------------- main

  initial begin
    logic [31:0] flen;
    bit          noisy;
    int          fed;
    int          file_no;
    int          guard;
    logic        f;
    logic [31:0] riff_seq;

    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_file_byte = '0;
    in_first_byte = 1'b0;
    len_reg = '0;
    clear_walk();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // zero file length ends the walk on byte zero; later bytes are dropped
    add_row(1, 32'h0, 8'h52, 1'b1, CHK_STATUS, ST_NOT_WAVE);
    add_row(0, 32'h0, 8'hFF, 1'b0, CHK_NONE, ST_OK);
    // bad riff tag, caught on byte three
    add_row(1, 32'hFFFF_FFFF, 8'h52, 1'b1, CHK_MODEL, ST_OK);
    add_row(0, 32'h0, 8'h49, 1'b0, CHK_MODEL, ST_OK);
    add_row(0, 32'h0, 8'h46, 1'b0, CHK_MODEL, ST_OK);
    add_row(0, 32'h0, 8'h58, 1'b0, CHK_STATUS, ST_NOT_WAVE);
    // data chunk before any fmt chunk
    riff_seq = TAG_RIFF;
    for (int i = 3; i >= 0; i--)
      add_row(0, 32'h0, riff_seq[i*8 +: 8], (i == 3), CHK_MODEL, ST_OK);
    add_row(0, 32'h0, 8'hFF, 1'b0, CHK_MODEL, ST_OK);
    add_row(0, 32'h0, 8'h00, 1'b0, CHK_MODEL, ST_OK);
    add_row(0, 32'h0, 8'hFF, 1'b0, CHK_MODEL, ST_OK);
    add_row(0, 32'h0, 8'h00, 1'b0, CHK_MODEL, ST_OK);
    for (int i = 3; i >= 0; i--) add_row(0, 32'h0, TAG_WAVE[i*8 +: 8], 1'b0, CHK_MODEL, ST_OK);
    for (int i = 3; i >= 0; i--) add_row(0, 32'h0, TAG_DATA[i*8 +: 8], 1'b0, CHK_MODEL, ST_OK);
    for (int i = 0; i < 3; i++) add_row(0, 32'h0, 8'h00, 1'b0, CHK_MODEL, ST_OK);
    add_row(0, 32'h0, 8'h00, 1'b0, CHK_STATUS, ST_DATA_EARLY);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].set_len) load_file_length(dir_tab[i].len);
      push_byte(dir_tab[i].b, dir_tab[i].f, dir_tab[i].chk, dir_tab[i].st);
    end

    fed = 0;
    file_no = 0;
    while (fed < 400) begin
      case (file_no % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 75; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 75; end
        default: begin tx_idle_pct = 37; rx_stall_pct = 37; end
      endcase
      build_file(flen, noisy);
      load_file_length(flen);
      foreach (file_q[i]) begin
        f = (i == 0) ? 1'b1 : (noisy && $urandom_range(0, 7) == 0);
        push_byte(file_q[i], f, CHK_MODEL, ST_OK);
      end
      fed += file_q.size();
      // stray requests after the file, normally ignored once the status is out
      if ($urandom_range(0, 2) == 0)
        repeat ($urandom_range(1, 3)) push_byte(8'($urandom), 1'b0, CHK_MODEL, ST_OK);
      file_no++;
    end

    in_valid <= 1'b0;
    guard = 0;
    while (parse_q.size() != 0 && guard < 5000) begin
      @(negedge clk);
      guard++;
    end
    repeat (10) @(negedge clk);
    if (bad_count == 0 && parse_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
